[rtl/ias_pkg.sv]
// ias_pkg: shared types and helpers for the interval activity selector
// holds the interval entry struct, cell control struct, fsm states and time compare
// no dependencies
`timescale 1ns / 1ps

package ias_pkg;

	localparam int TIME_W = 32;
	localparam int IDX_W = 6;

	typedef struct packed {
		logic signed [TIME_W-1:0] start_time;
		logic signed [TIME_W-1:0] end_time;
		logic [IDX_W-1:0] index;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	typedef struct packed {
		logic pop;
		logic done;
	} scan_stat_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	function automatic logic time_less(logic signed [TIME_W-1:0] a,
		logic signed [TIME_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

[rtl/ias_cell.sv]
// ias_cell: one slot of the sorting chain, ordered by end time
// inserts a broadcast item or shifts toward the head while draining
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ias_pkg::cell_ctrl_t ctrl,
	input  ias_pkg::entry_t   new_entry,
	input  logic              left_ins,
	input  logic              left_valid,
	input  ias_pkg::entry_t   left_entry,
	input  logic              right_valid,
	input  ias_pkg::entry_t   right_entry,
	output logic              ins,
	output logic              valid,
	output ias_pkg::entry_t   entry
);

	logic            valid_q;
	ias_pkg::entry_t entry_q;

	// strict compare keeps equal end times in load order
	assign ins = !valid_q || ias_pkg::time_less(new_entry.end_time, entry_q.end_time);
	assign valid = valid_q;
	assign entry = entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.load && ins) begin
			valid_q <= left_ins ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			entry_q <= right_entry;
		end else if (ctrl.load && ins) begin
			entry_q <= left_ins ? left_entry : new_entry;
		end
	end

endmodule

[rtl/ias_scan.sv]
// ias_scan: greedy selection at the head of the chain and the result register
// holds the newest selection back until it is known whether it is the final one
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_scan (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   active,
	input  logic                   head_valid,
	input  ias_pkg::entry_t        head_entry,
	input  logic                   overflow_flag,
	output ias_pkg::scan_stat_t    stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ias_pkg::IDX_W-1:0]         activity_index,
	output logic signed [ias_pkg::TIME_W-1:0] sel_start,
	output logic signed [ias_pkg::TIME_W-1:0] sel_end,
	output logic                   last_result,
	output logic                   overflow
);

	logic                            first_q;
	logic signed [ias_pkg::TIME_W-1:0] last_end_q;
	logic                            pend_valid_q;
	ias_pkg::entry_t                 pend_q;
	logic                            out_valid_q;
	ias_pkg::entry_t                 out_q;
	logic                            out_last_q;
	logic                            out_ovf_q;

	logic sel;
	logic out_free;
	logic take_head;
	logic move_pend;
	logic move_last;

	assign out_free = !out_valid_q || out_ready;
	assign sel = first_q || !ias_pkg::time_less(head_entry.start_time, last_end_q);

	always_comb begin
		stat = '0;
		take_head = 1'b0;
		move_pend = 1'b0;
		move_last = 1'b0;
		if (active) begin
			if (head_valid) begin
				// a selection moves the pending one to the output register, so that register must be free
				stat.pop = !(sel && pend_valid_q && !out_free);
				take_head = stat.pop && sel;
				move_pend = take_head && pend_valid_q;
			end else if (pend_valid_q) begin
				move_last = out_free;
				stat.done = out_free;
			end else begin
				stat.done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_head) begin
				first_q <= 1'b0;
				pend_valid_q <= 1'b1;
			end else if (move_last) begin
				pend_valid_q <= 1'b0;
			end
			if (stat.done) begin
				first_q <= 1'b1;
			end
			if (move_pend || move_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_head) begin
			pend_q <= head_entry;
			last_end_q <= head_entry.end_time;
		end
		if (move_pend || move_last) begin
			out_q <= pend_q;
			out_last_q <= move_last;
			out_ovf_q <= overflow_flag;
		end
	end

	assign out_valid = out_valid_q;
	assign activity_index = out_q.index;
	assign sel_start = out_q.start_time;
	assign sel_end = out_q.end_time;
	assign last_result = out_last_q;
	assign overflow = out_ovf_q;

endmodule

[rtl/interval_activity_selector.sv]
// interval_activity_selector: top level, load control, sorting chain and greedy scan
// depends on ias_pkg, ias_cell and ias_scan
`timescale 1ns / 1ps

// Intervals are taken one per cycle while the block loads a set; each is put
// in place on arrival in a chain of MAX_INTERVALS cells kept ordered by end
// time, equal end times in load order. The item flagged last_item closes the
// set; in_ready then stays low while the chain drains one cell per cycle
// through the greedy scan at its head, unless a selection waits on a stalled
// output, and the next set can load once the scan is done. Items past
// MAX_INTERVALS are dropped and every result of that set carries overflow.
// Results appear in end-time order and the final one carries last_result.
module interval_activity_selector #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [ias_pkg::TIME_W-1:0] start_time,
	input  logic signed [ias_pkg::TIME_W-1:0] end_time,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [ias_pkg::IDX_W-1:0]         activity_index,
	output logic signed [ias_pkg::TIME_W-1:0] sel_start,
	output logic signed [ias_pkg::TIME_W-1:0] sel_end,
	output logic        last_result,
	output logic        overflow
);

	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

	ias_pkg::state_t     state_q, state_d;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic                accept;
	logic                full;
	ias_pkg::cell_ctrl_t ctrl;
	ias_pkg::entry_t     new_entry;
	ias_pkg::scan_stat_t stat;

	logic [MAX_INTERVALS-1:0] ins;
	logic [MAX_INTERVALS-1:0] vld;
	ias_pkg::entry_t          ent [MAX_INTERVALS];

	assign in_ready = (state_q == ias_pkg::ST_LOAD);
	assign accept = in_valid && in_ready;
	assign full = (count_q == CNT_W'(MAX_INTERVALS));

	assign new_entry.start_time = start_time;
	assign new_entry.end_time = end_time;
	assign new_entry.index = ias_pkg::IDX_W'(count_q);

	assign ctrl.load = accept && !full;
	assign ctrl.shift = stat.pop;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ias_pkg::ST_LOAD: begin
				if (accept && last_item) begin
					state_d = ias_pkg::ST_DRAIN;
				end
			end
			ias_pkg::ST_DRAIN: begin
				if (stat.done) begin
					state_d = ias_pkg::ST_LOAD;
				end
			end
			default: state_d = ias_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ias_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (stat.done) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end else if (accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		logic            l_ins;
		logic            l_vld;
		ias_pkg::entry_t l_ent;
		logic            r_vld;
		ias_pkg::entry_t r_ent;

		if (i == 0) begin : g_head
			assign l_ins = 1'b0;
			assign l_vld = 1'b0;
			assign l_ent = '0;
		end else begin : g_mid
			assign l_ins = ins[i-1];
			assign l_vld = vld[i-1];
			assign l_ent = ent[i-1];
		end

		if (i == MAX_INTERVALS - 1) begin : g_tail
			assign r_vld = 1'b0;
			assign r_ent = '0;
		end else begin : g_body
			assign r_vld = vld[i+1];
			assign r_ent = ent[i+1];
		end

		ias_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_ins    (l_ins),
			.left_valid  (l_vld),
			.left_entry  (l_ent),
			.right_valid (r_vld),
			.right_entry (r_ent),
			.ins         (ins[i]),
			.valid       (vld[i]),
			.entry       (ent[i])
		);
	end

	ias_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.active         (state_q == ias_pkg::ST_DRAIN),
		.head_valid     (vld[0]),
		.head_entry     (ent[0]),
		.overflow_flag  (ovf_q),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.activity_index (activity_index),
		.sel_start      (sel_start),
		.sel_end        (sel_end),
		.last_result    (last_result),
		.overflow       (overflow)
	);

endmodule
